>>> rtl/assert_macros.svh
// Assertion helpers shared by the ring buffer RTL.
// Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ORB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen outside reset.
`define ORB_NEVER(label, cond, msg) \
    `ORB_ASSERT(label, !(cond), msg)

`endif

>>> rtl/orb_pkg.sv
package orb_pkg;

    // Field widths of the beat and config ports
    localparam int KIND_W = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 7;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 16;

    // Capacity after reset (clamped to DEPTH)
    localparam int CAP_RESET = 64;

    typedef enum logic [KIND_W-1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_SET   = 2'd2,
        OP_CLEAR = 2'd3
    } op_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch incoming op
        logic access;   // issue RAM read
        logic commit;   // write back, update pointers, load result
    } orb_cmd_t;

endpackage

>>> rtl/orb_ram.sv
module orb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/orb_ctrl.sv
`include "assert_macros.svh"

module orb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_ready,
    output logic              res_valid,
    input  logic              res_ready,
    output orb_pkg::orb_cmd_t cmd
);

    import orb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;

    assign op_ready    = (state_reg == S_IDLE);
    assign res_valid   = res_valid_reg;
    assign cmd.capture = op_valid && op_ready;
    assign cmd.access  = (state_reg == S_ACCESS);
    // result slot free, or its beat leaves this cycle
    assign cmd.commit  = (state_reg == S_FINISH) && (!res_valid_reg || res_ready);

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    `ORB_ASSERT(a_commit_once, cmd.commit |=> !cmd.commit, "commit repeated for one op")

endmodule

>>> rtl/orb_dp.sv
`include "assert_macros.svh"

module orb_dp #(
    parameter int DEPTH      = orb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = orb_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  orb_pkg::orb_cmd_t          cmd,
    input  logic                       cfg_wr_en,
    input  logic [orb_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic [orb_pkg::KIND_W-1:0] kind,
    input  logic [orb_pkg::POS_W-1:0]  position,
    input  logic [orb_pkg::VAL_W-1:0]  write_value,
    output logic [orb_pkg::VAL_W-1:0]  read_value,
    output logic                       out_of_range,
    output logic [orb_pkg::CNT_W-1:0]  entry_count,
    output logic                       is_empty
);

    import orb_pkg::*;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SUM_W   = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
    localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

    // buffer state
    logic [CNT_W-1:0]  cap_reg,    cap_next;
    logic [ADDR_W-1:0] oldest_reg, oldest_next;
    logic [ADDR_W-1:0] newest_reg, newest_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    // latched op
    op_kind_t          kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  val_reg;

    // result
    logic [VAL_W-1:0]  rv_reg,  rv_next;
    logic              oor_reg, oor_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              empty_reg;

    logic [SUM_W-1:0]      cap_ext;
    logic [SUM_W-1:0]      newest_inc;
    logic [SUM_W-1:0]      oldest_inc;
    logic [SUM_W-1:0]      phys_sum;
    logic [ADDR_W-1:0]     newest_adv;
    logic [ADDR_W-1:0]     oldest_adv;
    logic [ADDR_W-1:0]     phys_slot;
    logic [ADDR_W-1:0]     slot;
    logic                  hit;
    logic                  ram_we;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [CNT_W-1:0]      cap_clamp;

    // slot arithmetic, wraps at the configured capacity
    assign cap_ext    = SUM_W'(cap_reg);
    assign newest_inc = SUM_W'(newest_reg) + SUM_W'(1);
    assign oldest_inc = SUM_W'(oldest_reg) + SUM_W'(1);
    assign newest_adv = (newest_inc >= cap_ext) ? '0 : ADDR_W'(newest_inc);
    assign oldest_adv = (oldest_inc >= cap_ext) ? '0 : ADDR_W'(oldest_inc);
    assign phys_sum   = SUM_W'(oldest_reg) + SUM_W'(pos_reg);
    assign phys_slot  = (phys_sum >= cap_ext) ? ADDR_W'(phys_sum - cap_ext)
                                              : ADDR_W'(phys_sum);
    assign hit        = (pos_reg < count_reg);

    // put on empty reuses newest slot
    assign slot = (kind_reg == OP_PUT)
                ? ((count_reg != '0) ? newest_adv : newest_reg)
                : phys_slot;

    always_comb
    begin
        cap_clamp = cfg_wr_data;
        if (cfg_wr_data == '0)
        begin
            cap_clamp = CNT_W'(1);
        end
        else if (32'(cfg_wr_data) > DEPTH)
        begin
            cap_clamp = CNT_W'(DEPTH);
        end
    end

    always_comb
    begin
        cap_next    = cap_reg;
        oldest_next = oldest_reg;
        newest_next = newest_reg;
        count_next  = count_reg;
        ram_we      = 1'b0;
        rv_next     = '0;
        oor_next    = 1'b0;
        unique case (kind_reg)
            OP_PUT:
            begin
                ram_we      = cmd.commit;
                newest_next = slot;
                if (count_reg != '0)
                begin
                    if (newest_adv == oldest_reg)
                    begin
                        oldest_next = oldest_adv;   // full: drop oldest
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    count_next = CNT_W'(1);
                end
            end
            OP_GET, OP_SET:
            begin
                ram_we   = cmd.commit && hit && (kind_reg == OP_SET);
                rv_next  = hit ? VAL_W'(ram_rdata) : '0;
                oor_next = !hit;
            end
            OP_CLEAR:
            begin
                oldest_next = '0;
                newest_next = '0;
                count_next  = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        if (!cmd.commit)
        begin
            oldest_next = oldest_reg;
            newest_next = newest_reg;
            count_next  = count_reg;
        end
        if (cfg_wr_en)
        begin
            cap_next    = cap_clamp;
            oldest_next = '0;
            newest_next = '0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CNT_W'(CAP_RST);
            oldest_reg <= '0;
            newest_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            cap_reg    <= cap_next;
            oldest_reg <= oldest_next;
            newest_reg <= newest_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= op_kind_t'(kind);
            pos_reg  <= position;
            val_reg  <= write_value;
        end
        if (cmd.commit)
        begin
            rv_reg    <= rv_next;
            oor_reg   <= oor_next;
            cnt_reg   <= count_next;
            empty_reg <= (count_next == '0);
        end
    end

    orb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (DATA_WIDTH'(val_reg)),
        .re    (cmd.access),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign read_value   = rv_reg;
    assign out_of_range = oor_reg;
    assign entry_count  = cnt_reg;
    assign is_empty     = empty_reg;

    `ORB_NEVER(a_count_le_cap, count_reg > cap_reg, "entry count above capacity")
    `ORB_ASSERT(a_ptrs_in_cap,
        (SUM_W'(oldest_reg) < cap_ext) && (SUM_W'(newest_reg) < cap_ext),
        "slot pointer beyond capacity")
    `ORB_ASSERT(a_empty_ptrs, (count_reg == '0) |-> (oldest_reg == '0 && newest_reg == '0),
        "empty buffer with moved pointers")

endmodule

>>> rtl/overwriting_ring_buffer.sv
// Overwriting ring buffer: put / get / set / clear on a RAM-backed circular store.
// Each op steps through accept, RAM read and write-back, and the next op is accepted
//   only after the previous one is written back; it is taken even while that result waits.
// Reset (rst_n, async low): buffer empty, pointers zero, capacity min(64, DEPTH);
//   RAM contents are not cleared, only written entries are ever read.
module overwriting_ring_buffer #(
    parameter int DEPTH      = orb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = orb_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // config: capacity, any write also empties the buffer
    input  logic                       cfg_wr_en,
    input  logic [orb_pkg::CNT_W-1:0]  cfg_wr_data,
    // op channel
    input  logic                       op_valid,
    output logic                       op_ready,
    input  logic [orb_pkg::KIND_W-1:0] kind,
    input  logic [orb_pkg::POS_W-1:0]  position,
    input  logic [orb_pkg::VAL_W-1:0]  write_value,
    // result channel
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [orb_pkg::VAL_W-1:0]  read_value,
    output logic                       out_of_range,
    output logic [orb_pkg::CNT_W-1:0]  entry_count,
    output logic                       is_empty
);

    import orb_pkg::*;

    // Controller sequences each beat through three states and owns the
    // result valid flag; the datapath holds pointers, count, RAM and the
    // result payload register.
    orb_cmd_t cmd;

    orb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd)
    );

    // Datapath: logical index -> physical slot wraps at the capacity, so the
    // RAM address is oldest + position, less capacity once on overflow.
    orb_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .kind         (kind),
        .position     (position),
        .write_value  (write_value),
        .read_value   (read_value),
        .out_of_range (out_of_range),
        .entry_count  (entry_count),
        .is_empty     (is_empty)
    );

endmodule
